FILE: hdl/smsprng_pkg.sv
// ----------------------------------------------------------------------------
// smsprng_pkg
// Shared types and constants for the shuffled minimal-standard generator.
// ----------------------------------------------------------------------------
package smsprng_pkg;

  // width of the generator word and of every table entry
  localparam int unsigned DATA_W = 31;

  // multiplier width and the full product width
  localparam int unsigned MULT_W = 15;
  localparam int unsigned PROD_W = DATA_W + MULT_W;

  localparam logic [MULT_W-1:0] LCG_MULT = 15'd16807;
  localparam logic [DATA_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SEED_ONE = 31'd1;

  // width of the op selector on the input side
  localparam int unsigned OP_W = 1;
  localparam logic [OP_W-1:0] OP_DRAW   = 1'b0;
  localparam logic [OP_W-1:0] OP_RESEED = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WARM_MUL,
    ST_WARM_RED,
    ST_DRAW_MUL,
    ST_DRAW_RED,
    ST_DRAW_SWAP
  } state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic start_warm;
    logic use_seed;
    logic warm_mul;
    logic warm_red;
    logic draw_mul;
    logic draw_red;
    logic draw_swap;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic need_warm;
    logic warm_last;
  } sts_t;

endpackage

FILE: hdl/smsprng_ram.sv
// ----------------------------------------------------------------------------
// smsprng_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smsprng_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/smsprng_ctrl.sv
// ----------------------------------------------------------------------------
// smsprng_ctrl
// Sequencer for warm-up, draw and output hand-off.
// ----------------------------------------------------------------------------
module smsprng_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [smsprng_pkg::OP_W-1:0]        op_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  input  smsprng_pkg::sts_t                   sts_i,
  output smsprng_pkg::cmd_t                   cmd_o
);

  smsprng_pkg::state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                accept;
  logic                go_warm;

  // item accepted only in idle with the output slot free or draining
  assign in_ready_o = (state_q == smsprng_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign go_warm    = (op_i == smsprng_pkg::OP_RESEED) || sts_i.need_warm;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      smsprng_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = go_warm ? smsprng_pkg::ST_WARM_MUL : smsprng_pkg::ST_DRAW_MUL;
        end
      end
      smsprng_pkg::ST_WARM_MUL: begin
        state_d = smsprng_pkg::ST_WARM_RED;
      end
      smsprng_pkg::ST_WARM_RED: begin
        state_d = sts_i.warm_last ? smsprng_pkg::ST_DRAW_MUL : smsprng_pkg::ST_WARM_MUL;
      end
      smsprng_pkg::ST_DRAW_MUL: begin
        state_d = smsprng_pkg::ST_DRAW_RED;
      end
      smsprng_pkg::ST_DRAW_RED: begin
        state_d = smsprng_pkg::ST_DRAW_SWAP;
      end
      smsprng_pkg::ST_DRAW_SWAP: begin
        state_d = smsprng_pkg::ST_IDLE;
      end
      default: begin
        state_d = smsprng_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o            = '0;
    cmd_o.start_warm = accept && go_warm;
    cmd_o.use_seed   = (op_i == smsprng_pkg::OP_RESEED);
    case (state_q)
      smsprng_pkg::ST_WARM_MUL:  cmd_o.warm_mul  = 1'b1;
      smsprng_pkg::ST_WARM_RED:  cmd_o.warm_red  = 1'b1;
      smsprng_pkg::ST_DRAW_MUL:  cmd_o.draw_mul  = 1'b1;
      smsprng_pkg::ST_DRAW_RED:  cmd_o.draw_red  = 1'b1;
      smsprng_pkg::ST_DRAW_SWAP: cmd_o.draw_swap = 1'b1;
      default: begin
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == smsprng_pkg::ST_DRAW_SWAP) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smsprng_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hdl/smsprng_dp.sv
// ----------------------------------------------------------------------------
// smsprng_dp
// Generator datapath: modular multiply, shuffle table, slot select, output.
// ----------------------------------------------------------------------------
module smsprng_dp #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  smsprng_pkg::cmd_t                  cmd_i,
  output smsprng_pkg::sts_t                  sts_o,
  input  logic [smsprng_pkg::DATA_W-1:0]     seed_i,
  output logic [smsprng_pkg::DATA_W-1:0]     random_value_o,
  output logic [smsprng_pkg::DATA_W-1:0]     generator_word_o
);

  localparam int unsigned DW = smsprng_pkg::DATA_W;
  localparam int unsigned PW = smsprng_pkg::PROD_W;
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 8);
  // slot divisor and its truncated reciprocal scaled by 2^31
  localparam logic [DW-1:0] SLOT_DIV =
    DW'(64'd1 + (64'h7FFF_FFFE / 64'(TABLE_DEPTH)));
  localparam int unsigned QW = 7;
  localparam logic [QW-1:0] SLOT_RCP = QW'(64'h8000_0000 / 64'(SLOT_DIV));
  localparam int unsigned EW = DW + QW;

  logic [DW-1:0] lcg_q;
  logic [DW-1:0] last_q;
  logic [PW-1:0] prod_q;
  logic [CW-1:0] cnt_q;
  logic [QW-1:0] slot_est_q;
  logic [AW-1:0] slot_q;
  logic [DW-1:0] rand_q;
  logic [DW-1:0] gen_q;

  logic [DW-1:0] seed_val;
  logic [DW:0]   red_sum;
  logic [DW-1:0] red;
  logic [EW-1:0] est_prod;
  logic [EW-1:0] back_prod;
  logic [EW-1:0] rem;
  logic [QW-1:0] slot_inc;
  logic [AW-1:0] slot_fix;
  logic          cnt_in_table;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [DW-1:0] ram_rdata;

  // seed mapping: zero and the modulus itself both become one
  always_comb begin
    seed_val = smsprng_pkg::SEED_ONE;
    if (cmd_i.use_seed && seed_i != '0 && seed_i != smsprng_pkg::LCG_MOD) begin
      seed_val = seed_i;
    end
  end

  // mersenne reduction of the registered product
  assign red_sum = {1'b0, prod_q[DW-1:0]} + (DW+1)'(prod_q[PW-1:DW]);
  assign red     = (red_sum >= {1'b0, smsprng_pkg::LCG_MOD})
                 ? DW'(red_sum - {1'b0, smsprng_pkg::LCG_MOD})
                 : red_sum[DW-1:0];

  // slot estimate from the previous output, low by at most one
  assign est_prod = EW'(last_q) * EW'(SLOT_RCP);

  // slot correction and guard clamp
  assign back_prod = EW'(slot_est_q) * EW'(SLOT_DIV);
  assign rem       = EW'(last_q) - back_prod;
  assign slot_inc  = (rem >= EW'(SLOT_DIV)) ? slot_est_q + QW'(1) : slot_est_q;
  assign slot_fix  = (slot_inc >= QW'(TABLE_DEPTH)) ? AW'(TABLE_DEPTH - 1)
                                                    : slot_inc[AW-1:0];

  assign cnt_in_table = (cnt_q < CW'(TABLE_DEPTH));

  // generator, warm-up counter and previous-output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcg_q  <= smsprng_pkg::SEED_ONE;
      last_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.start_warm) begin
        lcg_q <= seed_val;
        cnt_q <= CW'(TABLE_DEPTH + 7);
      end
      if (cmd_i.warm_red) begin
        lcg_q <= red;
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == '0) begin
          last_q <= red;
        end
      end
      if (cmd_i.draw_red) begin
        lcg_q <= red;
      end
      if (cmd_i.draw_swap) begin
        last_q <= ram_rdata;
      end
    end
  end

  // product, slot and output payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.warm_mul || cmd_i.draw_mul) begin
      prod_q <= PW'(lcg_q) * PW'(smsprng_pkg::LCG_MULT);
    end
    if (cmd_i.draw_mul) begin
      slot_est_q <= est_prod[EW-1:DW];
    end
    if (cmd_i.draw_red) begin
      slot_q <= slot_fix;
    end
    if (cmd_i.draw_swap) begin
      rand_q <= ram_rdata;
      gen_q  <= lcg_q;
    end
  end

  // shuffle table port control
  assign ram_we    = (cmd_i.warm_red && cnt_in_table) || cmd_i.draw_swap;
  assign ram_waddr = cmd_i.warm_red ? cnt_q[AW-1:0] : slot_q;
  assign ram_wdata = cmd_i.warm_red ? red : lcg_q;

  smsprng_ram #(
    .WIDTH (DW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (slot_fix),
    .rdata_o (ram_rdata)
  );

  assign sts_o.need_warm = (last_q == '0);
  assign sts_o.warm_last = (cnt_q == '0);

  assign random_value_o   = rand_q;
  assign generator_word_o = gen_q;

endmodule

FILE: hdl/shuffled_minimal_standard_prng_top.sv
// ----------------------------------------------------------------------------
// shuffled_minimal_standard_prng_top
// Park-Miller minimal-standard generator with a Bays-Durham shuffle table.
// ----------------------------------------------------------------------------
// Each input item draws one 31-bit number; tuser selects a plain draw or a
// reseed from tdata. A plain draw runs one multiply by 16807, one reduction
// modulo 2^31-1, then a registered read and write-back of the shuffle table
// before its result is offered; no new item is taken while a draw is in
// progress. A reseed, and the first draw after reset, first runs a warm-up of
// TABLE_DEPTH + 8 generator steps, each a multiply and a reduction on the
// shared multiplier. The next item is accepted once the block is idle and the
// previous result has been taken or is being taken.
module shuffled_minimal_standard_prng_top #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [30:0] seed, [31] zero pad
  input  logic [0:0]  s_axis_tuser_i,  // [0] op
  // result item
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o   // [30:0] random_value, [61:31] generator_word,
                                       // [63:62] zero pad
);

  smsprng_pkg::cmd_t               cmd;
  smsprng_pkg::sts_t               sts;
  logic [smsprng_pkg::DATA_W-1:0]  random_value;
  logic [smsprng_pkg::DATA_W-1:0]  generator_word;

  // sequencer
  smsprng_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .op_i        (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // generator datapath
  smsprng_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .seed_i           (s_axis_tdata_i[smsprng_pkg::DATA_W-1:0]),
    .random_value_o   (random_value),
    .generator_word_o (generator_word)
  );

  // pack the result item
  assign m_axis_tdata_o = {2'b00, generator_word, random_value};

endmodule
